// ===== hdl/idtp_pkg.sv =====
package idtp_pkg;

  // Format selector codes
  localparam logic [1:0] MODE_DATE  = 2'd0;
  localparam logic [1:0] MODE_TIME  = 2'd1;
  localparam logic [1:0] MODE_STAMP = 2'd2;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Fraction digits that still carry weight
  localparam logic [3:0] FRAC_DIGITS_MAX = 4'd9;

  // Position in the format
  typedef enum logic [21:0] {
    PH_Y0     = 22'h000001,
    PH_Y1     = 22'h000002,
    PH_Y2     = 22'h000004,
    PH_Y3     = 22'h000008,
    PH_DASH1  = 22'h000010,
    PH_M0     = 22'h000020,
    PH_M1     = 22'h000040,
    PH_DASH2  = 22'h000080,
    PH_D0     = 22'h000100,
    PH_D1     = 22'h000200,
    PH_SEP    = 22'h000400,
    PH_H0     = 22'h000800,
    PH_H1     = 22'h001000,
    PH_COLON1 = 22'h002000,
    PH_N0     = 22'h004000,
    PH_N1     = 22'h008000,
    PH_COLON2 = 22'h010000,
    PH_S0     = 22'h020000,
    PH_S1     = 22'h040000,
    PH_DOT    = 22'h080000,
    PH_FRAC   = 22'h100000,
    PH_DONE   = 22'h200000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        failed;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [29:0] nanos;
    logic [3:0]  frac_cnt;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [29:0] fraction_ns;
  } result_t;

  // Start-of-string parse state
  function automatic parse_state_t clear_state();
    parse_state_t s;
    s.phase    = PH_Y0;
    s.failed   = 1'b0;
    s.year     = '0;
    s.month    = '0;
    s.day      = '0;
    s.hour     = '0;
    s.minute   = '0;
    s.second   = '0;
    s.nanos    = '0;
    s.frac_cnt = '0;
    return s;
  endfunction

endpackage

// ===== hdl/idtp_ifs.sv =====
interface idtp_in_if import idtp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       is_last;

  modport source (output valid, output text_char, output is_last, input ready);
  modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

interface idtp_out_if import idtp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        ok;
  logic [13:0] year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic [29:0] fraction_ns;

  modport source (output valid, output ok, output year, output month, output day,
                  output hour, output minute, output second, output fraction_ns,
                  input ready);
  modport sink   (input valid, input ok, input year, input month, input day,
                  input hour, input minute, input second, input fraction_ns,
                  output ready);
endinterface

interface idtp_cfg_if import idtp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] format_mode;

  modport source (output valid, output format_mode, input ready);
  modport sink   (input valid, input format_mode, output ready);
endinterface

// ===== hdl/iso_date_time_text_parser_core.sv =====
// ISO 8601 date / time / timestamp parser. Feed one character per request on
// in_req, with is_last set on the final character; the block answers each
// string with exactly one result on out_rsp (ok = 0 and all fields zero on a
// bad character or a string that ends early). cfg_wr.format_mode selects
// date (0), time (1) or timestamp (2, reset default); write it only while no
// string is in flight. The block takes one character every cycle unless a
// waiting result stalls it: each character passes an input register and one
// step of digit accumulate and position update, and a string's result is
// registered in the output register when its last character is stepped. A
// result that waits on out_rsp.ready stalls the input only when another
// string's last character reaches the step logic.
module iso_date_time_text_parser_core import idtp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  idtp_in_if.sink    in_req,
  idtp_out_if.source out_rsp,
  idtp_cfg_if.sink   cfg_wr
);

  logic         in_v_r, in_v_nxt;
  logic [7:0]   in_char_r, in_char_nxt;
  logic         in_last_r, in_last_nxt;
  logic         out_v_r, out_v_nxt;
  result_t      res_r, res_nxt;
  parse_state_t st_r, st_nxt;
  logic [1:0]   mode_r, mode_nxt;

  parse_state_t step_st;
  result_t      step_res;
  logic         advance;
  logic         in_take;

  idtp_step u_step (
    .st_cur    (st_r),
    .text_char (in_char_r),
    .mode      (mode_r),
    .st_nxt    (step_st),
    .result    (step_res)
  );

  // Step the held character unless its result has nowhere to go
  assign advance = in_v_r && (!in_last_r || !out_v_r || out_rsp.ready);
  assign in_req.ready = !in_v_r || advance;
  assign in_take = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;

  // Next values for input stage, parse state, result and mode
  always_comb begin
    in_v_nxt    = in_take ? 1'b1 : (advance ? 1'b0 : in_v_r);
    in_char_nxt = in_take ? in_req.text_char : in_char_r;
    in_last_nxt = in_take ? in_req.is_last : in_last_r;

    st_nxt = st_r;
    if (advance) begin
      st_nxt = in_last_r ? clear_state() : step_st;
    end

    out_v_nxt = out_v_r;
    res_nxt   = res_r;
    if (advance && in_last_r) begin
      out_v_nxt = 1'b1;
      res_nxt   = step_res;
    end else if (out_rsp.ready) begin
      out_v_nxt = 1'b0;
    end

    mode_nxt = cfg_wr.valid ? cfg_wr.format_mode : mode_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= clear_state();
      mode_r  <= MODE_STAMP;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      st_r    <= st_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    in_char_r <= in_char_nxt;
    in_last_r <= in_last_nxt;
    res_r     <= res_nxt;
  end

  assign out_rsp.valid       = out_v_r;
  assign out_rsp.ok          = res_r.ok;
  assign out_rsp.year        = res_r.year;
  assign out_rsp.month       = res_r.month;
  assign out_rsp.day         = res_r.day;
  assign out_rsp.hour        = res_r.hour;
  assign out_rsp.minute      = res_r.minute;
  assign out_rsp.second      = res_r.second;
  assign out_rsp.fraction_ns = res_r.fraction_ns;

endmodule

// ===== hdl/idtp_step.sv =====
module idtp_step import idtp_pkg::*; (
  input  parse_state_t st_cur,
  input  logic [7:0]   text_char,
  input  logic [1:0]   mode,
  output parse_state_t st_nxt,
  output result_t      result
);

  // One decimal digit into a field accumulator
  function automatic logic [13:0] dec_acc(input logic [13:0] acc, input logic [3:0] d);
    return acc * 14'd10 + {10'b0, d};
  endfunction

  // Place value of a fraction digit in nanoseconds
  function automatic logic [26:0] frac_weight(input logic [3:0] idx);
    logic [26:0] w;
    case (idx)
      4'd0:    w = 27'd100000000;
      4'd1:    w = 27'd10000000;
      4'd2:    w = 27'd1000000;
      4'd3:    w = 27'd100000;
      4'd4:    w = 27'd10000;
      4'd5:    w = 27'd1000;
      4'd6:    w = 27'd100;
      4'd7:    w = 27'd10;
      4'd8:    w = 27'd1;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

  phase_t     p;
  logic       digit;
  logic       hold;
  logic [3:0] d;

  // Advance the parse by one character
  always_comb begin
    st_nxt = st_cur;
    p      = st_cur.phase;
    digit  = (text_char inside {[CH_ZERO:CH_NINE]});
    d      = digit ? 4'(text_char - CH_ZERO) : 4'd0;
    hold   = st_cur.failed || (st_cur.phase == PH_DONE);

    // time-only strings skip the date
    if (p == PH_Y0 && mode == MODE_TIME) begin
      p = PH_H0;
    end

    // optional separator between date and time
    if (!hold && p == PH_SEP) begin
      if (text_char == CH_SPACE || text_char == CH_T) begin
        st_nxt.phase = PH_H0;
        hold         = 1'b1;
      end else begin
        p = PH_H0;
      end
    end

    if (!hold) begin
      case (p)
        PH_DOT: begin
          st_nxt.phase = (text_char == CH_DOT) ? PH_FRAC : PH_DONE;
        end
        PH_FRAC: begin
          if (!digit) begin
            st_nxt.phase = PH_DONE;
          end else if (st_cur.frac_cnt < FRAC_DIGITS_MAX) begin
            st_nxt.nanos    = st_cur.nanos + (30'(d) * 30'(frac_weight(st_cur.frac_cnt)));
            st_nxt.frac_cnt = st_cur.frac_cnt + 4'd1;
          end
        end
        PH_DASH1, PH_DASH2: begin
          if (text_char != CH_DASH) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.phase = (p == PH_DASH1) ? PH_M0 : PH_D0;
          end
        end
        PH_COLON1, PH_COLON2: begin
          if (text_char != CH_COLON) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.phase = (p == PH_COLON1) ? PH_N0 : PH_S0;
          end
        end
        PH_Y0, PH_Y1, PH_Y2, PH_Y3: begin
          if (!digit) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.year = dec_acc(st_cur.year, d);
            case (p)
              PH_Y0:   st_nxt.phase = PH_Y1;
              PH_Y1:   st_nxt.phase = PH_Y2;
              PH_Y2:   st_nxt.phase = PH_Y3;
              default: st_nxt.phase = PH_DASH1;
            endcase
          end
        end
        PH_M0, PH_M1: begin
          if (!digit) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.month = 7'(dec_acc({7'b0, st_cur.month}, d));
            st_nxt.phase = (p == PH_M0) ? PH_M1 : PH_DASH2;
          end
        end
        PH_D0, PH_D1: begin
          if (!digit) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.day = 7'(dec_acc({7'b0, st_cur.day}, d));
            if (p == PH_D0) begin
              st_nxt.phase = PH_D1;
            end else begin
              st_nxt.phase = (mode == MODE_DATE) ? PH_DONE : PH_SEP;
            end
          end
        end
        PH_H0, PH_H1: begin
          if (!digit) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.hour  = 7'(dec_acc({7'b0, st_cur.hour}, d));
            st_nxt.phase = (p == PH_H0) ? PH_H1 : PH_COLON1;
          end
        end
        PH_N0, PH_N1: begin
          if (!digit) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.minute = 7'(dec_acc({7'b0, st_cur.minute}, d));
            st_nxt.phase  = (p == PH_N0) ? PH_N1 : PH_COLON2;
          end
        end
        PH_S0, PH_S1: begin
          if (!digit) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.second = 7'(dec_acc({7'b0, st_cur.second}, d));
            if (p == PH_S0) begin
              st_nxt.phase = PH_S1;
            end else begin
              st_nxt.phase = (mode == MODE_TIME) ? PH_DONE : PH_DOT;
            end
          end
        end
        default: begin
          st_nxt.phase = st_cur.phase;
        end
      endcase
    end
  end

  // Build the result; zero every field unless the string parsed ok
  always_comb begin
    result.ok = !st_nxt.failed &&
                (st_nxt.phase == PH_DONE || st_nxt.phase == PH_DOT ||
                 st_nxt.phase == PH_FRAC);
    result.year        = result.ok ? st_nxt.year   : '0;
    result.month       = result.ok ? st_nxt.month  : '0;
    result.day         = result.ok ? st_nxt.day    : '0;
    result.hour        = result.ok ? st_nxt.hour   : '0;
    result.minute      = result.ok ? st_nxt.minute : '0;
    result.second      = result.ok ? st_nxt.second : '0;
    result.fraction_ns = result.ok ? st_nxt.nanos  : '0;
  end

endmodule

// ===== tb/sv/tb_iso_date_time_text_parser_core.sv =====
`timescale 1ns / 1ps

module tb_iso_date_time_text_parser_core;
  import idtp_pkg::*;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_beat_t;

  bit   clk;
  logic rst_n;

  idtp_in_if  in_bus();
  idtp_out_if out_bus();
  idtp_cfg_if cfg_bus();

  iso_date_time_text_parser_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_bus),
    .out_rsp (out_bus),
    .cfg_wr  (cfg_bus)
  );

  // Characters waiting to be sent, and parse results still to arrive
  text_beat_t text_q[$];
  result_t    parsed_q[$];
  bit [7:0]   text_buf[$];
  text_beat_t beat;

  // Shadow parser state and selected format
  parse_state_t st;
  logic [1:0]   fmt_sel;

  int  send_idle_pct;
  int  recv_stall_pct;
  int  queued_chars;
  int  mismatches;
  bit  char_taken;
  bit  hold_req;
  logic rx_hold;

  // Per-phase settings: format, sender idle and receiver stall percentages
  localparam int NUM_PHASES = 8;
  localparam int PHASE_CHARS = 170;
  localparam logic [1:0] PH_MODE [NUM_PHASES] =
    '{MODE_STAMP, MODE_DATE, MODE_TIME, 2'd3, MODE_STAMP, MODE_DATE, MODE_TIME, MODE_STAMP};
  localparam int PH_SEND [NUM_PHASES] = '{0, 73, 0, 29, 73, 0, 29, 0};
  localparam int PH_RECV [NUM_PHASES] = '{0, 0, 73, 29, 0, 73, 29, 0};

  initial begin
    forever #10 clk = ~clk;
  end

  // Nanosecond weight of the fraction digit at position k
  function automatic logic [29:0] place_weight(logic [3:0] k);
    logic [29:0] w;
    w = 30'd100000000;
    for (int i = 0; i < k; i++) w = w / 10;
    return w;
  endfunction

  // Advance the shadow parser by one character; on the last one, queue the result
  task automatic parse_char(input logic [7:0] c, input logic last);
    logic    dig;
    logic [3:0] d;
    phase_t  p;
    result_t r;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d = dig ? 4'(c - CH_ZERO) : 4'd0;
    p = st.phase;
    if (!st.failed && st.phase != PH_DONE) begin
      if (p == PH_Y0 && fmt_sel == MODE_TIME) p = PH_H0;
      if (p == PH_SEP && (c == CH_SPACE || c == CH_T)) begin
        st.phase = PH_H0;
      end else begin
        if (p == PH_SEP) p = PH_H0;
        case (p)
          PH_DOT: begin
            if (c == CH_DOT) st.phase = PH_FRAC;
            else st.phase = PH_DONE;
          end
          PH_FRAC: begin
            if (!dig) begin
              st.phase = PH_DONE;
            end else if (st.frac_cnt < FRAC_DIGITS_MAX) begin
              st.nanos = st.nanos + d * place_weight(st.frac_cnt);
              st.frac_cnt = st.frac_cnt + 4'd1;
            end
          end
          PH_DASH1, PH_DASH2: begin
            if (c == CH_DASH) st.phase = phase_t'(p << 1);
            else st.failed = 1'b1;
          end
          PH_COLON1, PH_COLON2: begin
            if (c == CH_COLON) st.phase = phase_t'(p << 1);
            else st.failed = 1'b1;
          end
          default: begin
            if (!dig) begin
              st.failed = 1'b1;
            end else begin
              if (p < PH_DASH1) st.year = 14'(st.year * 10 + d);
              else if (p < PH_DASH2) st.month = 7'(st.month * 10 + d);
              else if (p < PH_SEP) st.day = 7'(st.day * 10 + d);
              else if (p < PH_COLON1) st.hour = 7'(st.hour * 10 + d);
              else if (p < PH_COLON2) st.minute = 7'(st.minute * 10 + d);
              else st.second = 7'(st.second * 10 + d);
              // the day and second fields end the format in date and time modes
              if (p == PH_D1) begin
                if (fmt_sel == MODE_DATE) st.phase = PH_DONE;
                else st.phase = PH_SEP;
              end else if (p == PH_S1) begin
                if (fmt_sel == MODE_TIME) st.phase = PH_DONE;
                else st.phase = PH_DOT;
              end else begin
                st.phase = phase_t'(p << 1);
              end
            end
          end
        endcase
      end
    end
    if (last) begin
      r = '0;
      if (!st.failed && (st.phase == PH_DONE || st.phase == PH_DOT || st.phase == PH_FRAC))
      begin
        r.ok          = 1'b1;
        r.year        = st.year;
        r.month       = st.month;
        r.day         = st.day;
        r.hour        = st.hour;
        r.minute      = st.minute;
        r.second      = st.second;
        r.fraction_ns = st.nanos;
      end
      parsed_q.push_back(r);
      st = '0;
      st.phase = PH_Y0;
    end
  endtask

  // Move the text buffer into the send queue; an empty string is one zero character
  task automatic queue_text();
    if (text_buf.size() == 0) text_buf.push_back(8'd0);
    foreach (text_buf[i]) begin
      text_q.push_back('{text_buf[i], i == text_buf.size() - 1});
      queued_chars++;
    end
    text_buf.delete();
  endtask

  task automatic queue_string(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    queue_text();
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  // Well-formed text for a format, with random fields and an optional zone or digit tail
  function automatic string well_formed(logic [1:0] m);
    string dt, tm, s;
    dt = {rand_digits(4), "-", rand_digits(2), "-", rand_digits(2)};
    tm = {rand_digits(2), ":", rand_digits(2), ":", rand_digits(2)};
    if (m == MODE_DATE) begin
      s = dt;
    end else if (m == MODE_TIME) begin
      s = tm;
    end else begin
      case ($urandom_range(2))
        0: s = {dt, tm};
        1: s = {dt, " ", tm};
        default: s = {dt, "T", tm};
      endcase
      if ($urandom_range(3) != 0) s = {s, ".", rand_digits($urandom_range(12))};
    end
    case ($urandom_range(6))
      0: s = {s, "Z"};
      1: s = {s, "+05:30"};
      2: s = {s, "-0800"};
      3: s = {s, ".", rand_digits(3)};
      default: ;
    endcase
    return s;
  endfunction

  // Mostly well-formed text, some in the wrong format, some cut or corrupted, some noise
  task automatic queue_random_text(input logic [1:0] m);
    string s;
    int    pick;
    int    hit;
    pick = $urandom_range(99);
    if (pick < 6) begin
      repeat ($urandom_range(6)) text_buf.push_back(8'($urandom_range(255)));
    end else begin
      if (pick < 14) s = well_formed(2'($urandom_range(3)));
      else s = well_formed(m);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      hit = $urandom_range(99);
      if (hit < 10) begin
        text_buf = text_buf[0 : $urandom_range(text_buf.size() - 1)];
      end else if (hit < 20) begin
        text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
      end
    end
    queue_text();
  endtask

  task automatic write_format(input logic [1:0] m);
    @(negedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.format_mode <= m;
    do @(posedge clk); while (!cfg_bus.ready);
    fmt_sel = m;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait until every character is taken and every result is back, then let the pipe settle
  task automatic wait_quiet();
    int n;
    n = 0;
    while ((text_q.size() != 0 || in_bus.valid || parsed_q.size() != 0) && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Record accepted characters in the shadow parser
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      parse_char(in_bus.text_char, in_bus.is_last);
      char_taken = 1'b1;
    end
  end

  // Offer the next character, holding it until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || char_taken) begin
      char_taken = 1'b0;
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        beat = text_q.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.text_char <= beat.code;
        in_bus.is_last   <= beat.last;
      end else begin
        in_bus.valid     <= 1'b0;
        in_bus.text_char <= 8'($urandom_range(255));
        in_bus.is_last   <= 1'($urandom_range(1));
      end
    end
  end

  // Stall the result side at random, or fully during a hold-off
  always @(negedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    rx_hold = 1'b0;
    wait (hold_req);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // Compare each returned result with the oldest prediction
  always @(posedge clk) begin
    result_t r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (parsed_q.size() == 0) begin
        $display("%0t: unexpected result, ok %0d year %0d", $time, out_bus.ok, out_bus.year);
        mismatches++;
      end else begin
        r = parsed_q.pop_front();
        check_field("ok", r.ok, out_bus.ok);
        check_field("year", r.year, out_bus.year);
        check_field("month", r.month, out_bus.month);
        check_field("day", r.day, out_bus.day);
        check_field("hour", r.hour, out_bus.hour);
        check_field("minute", r.minute, out_bus.minute);
        check_field("second", r.second, out_bus.second);
        check_field("fraction_ns", r.fraction_ns, out_bus.fraction_ns);
      end
    end
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.text_char    = 8'd0;
    in_bus.is_last      = 1'b0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.format_mode = MODE_STAMP;
    st                  = '0;
    st.phase            = PH_Y0;
    fmt_sel             = MODE_STAMP;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    queued_chars        = 0;
    mismatches          = 0;
    char_taken          = 1'b0;
    hold_req            = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: timestamp at the reset format
    queue_string("2024-01-15T10:20:30.123456789");
    queue_string("9999-99-99 99:99:99.999999999999");
    queue_string("0000-00-0000:00:00");
    queue_string("2024-01-15 10:20:30.");
    queue_string("2024-01-15T10:20:30Z");
    queue_string("2024-01-15T10:20:30.5+02:00");
    queue_string("");
    queue_string("2024-01-15T10:20");
    queue_string("2024-01-15T10:20:30");
    queue_string("2024/01/15T10:20:30");
    queue_string("2024-01-15TT10:20:30");
    wait_quiet();

    // Directed: date only
    write_format(MODE_DATE);
    queue_string("2024-12-31");
    queue_string("2024-12-31T23:59:59");
    queue_string("2024-12-3");
    queue_string("abcd");
    wait_quiet();

    // Directed: time only
    write_format(MODE_TIME);
    queue_string("23:59:59");
    queue_string("23:59:59.123");
    queue_string("23-59");
    queue_string("");
    wait_quiet();

    // Directed: the unused format code acts as timestamp
    write_format(2'd3);
    queue_string("2024-01-15T10:20:30.1");
    queue_string("2024-01-15");
    wait_quiet();

    // Random phases across formats and idle patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_format(PH_MODE[ph]);
      send_idle_pct  = PH_SEND[ph];
      recv_stall_pct = PH_RECV[ph];
      queued_chars   = 0;
      if (ph == NUM_PHASES - 1) begin
        hold_req = 1'b1;
        repeat (12) begin
          if ($urandom_range(1) == 0) queue_string("");
          else queue_random_text(PH_MODE[ph]);
        end
      end
      while (queued_chars < PHASE_CHARS) queue_random_text(PH_MODE[ph]);
      wait_quiet();
    end

    if (parsed_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, parsed_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
